/* src/pidt_pkg.sv */
// ----------------------------------------------------------------------------
// pidt_pkg: shared types and constants of the positional insert/delete table
// Holds the payload widths, the operation codes and the command word that
// is broadcast from the control logic to every cell of the table.
// ----------------------------------------------------------------------------
package pidt_pkg;

   localparam int POS_W  = 8;
   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int LEN_OUT_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_SET_LENGTH = 3'd0,
      OP_READ       = 3'd1,
      OP_INSERT     = 3'd2,
      OP_EDIT       = 3'd3,
      OP_DELETE     = 3'd4
   } pidt_op_type;

   // Command broadcast to all cells; enables are already qualified
   typedef struct packed {
      logic                     ins;
      logic                     del;
      logic                     edit;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
   } pidt_cmd_type;

endpackage

/* src/pidt_if.sv */
// ----------------------------------------------------------------------------
// pidt_if: request and response channels of the table
// Valid/ready channels; a word moves at a rising edge with valid and ready.
// ----------------------------------------------------------------------------
interface pidt_req_if;
   import pidt_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          opcode;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] entry_value;

   modport source (output valid, output opcode, output position, output entry_value,
                   input ready);
   modport sink   (input valid, input opcode, input position, input entry_value,
                   output ready);
endinterface

interface pidt_rsp_if;
   import pidt_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     status;
   logic signed [DATA_W-1:0] read_value;
   logic [LEN_OUT_W-1:0]     current_length;

   modport source (output valid, output status, output read_value, output current_length,
                   input ready);
   modport sink   (input valid, input status, input read_value, input current_length,
                   output ready);
endinterface

/* src/positional_insert_delete_table.sv */
// Positional insert/delete table: an ordered list of up to DEPTH signed 32-bit
// entries with a current length, built as a row of DEPTH cells that each hold
// one entry and load from their left or right neighbor. Every operation (set
// length, read, insert, edit, delete) is done in the cycle its word is taken,
// shifts included, so the table accepts one request word per clock unless a
// waiting response is held back; the response word appears in the cycle after
// acceptance from an output register, and a new request is taken while that
// response is still waiting as long as the response is taken at the same
// edge. The read path is a DEPTH-to-one mux over the cells. Entries have no
// reset and need no clearing pass; only len_ff and rsp_valid_ff are reset.
// ----------------------------------------------------------------------------
// positional_insert_delete_table: top level
// Validates each request, broadcasts the command to the cell row, keeps the
// length and registers the response word.
// ----------------------------------------------------------------------------
module positional_insert_delete_table import pidt_pkg::*; #(
   parameter int DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   pidt_req_if.sink   req_bus,
   pidt_rsp_if.source rsp_bus
);

   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   logic [LEN_W-1:0]         len_ff;
   logic [LEN_W-1:0]         len_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_status_ff;
   logic                     rsp_status_in;
   logic signed [DATA_W-1:0] rsp_read_ff;
   logic signed [DATA_W-1:0] rsp_read_in;
   logic [LEN_OUT_W-1:0]     rsp_len_ff;

   logic                     accept;
   logic [CMP_W-1:0]         pos_c;
   logic [CMP_W-1:0]         len_c;
   logic                     below_len;
   logic                     ok;
   pidt_cmd_type             cmd;
   logic signed [DATA_W-1:0] cell_entry [DEPTH];

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign pos_c     = CMP_W'(req_bus.position);
   assign len_c     = CMP_W'(len_ff);
   assign below_len = (pos_c < len_c) && (pos_c < DEPTH_C);

   // Validate the request and work out the new length
   always_comb begin
      ok     = 1'b0;
      len_in = len_ff;
      unique case (req_bus.opcode) inside
         OP_SET_LENGTH: begin
            if (pos_c > DEPTH_C) begin
               len_in = '0;
            end else begin
               ok     = 1'b1;
               len_in = LEN_W'(req_bus.position);
            end
         end
         OP_READ, OP_EDIT: begin
            ok = below_len;
         end
         OP_INSERT: begin
            ok = (pos_c <= len_c) && (len_c < DEPTH_C);
            if (ok) begin
               len_in = len_ff + 1'b1;
            end
         end
         OP_DELETE: begin
            ok = below_len;
            if (ok) begin
               len_in = len_ff - 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // Broadcast the qualified command to the cell row
   always_comb begin
      cmd.ins   = accept && ok && (req_bus.opcode == OP_INSERT);
      cmd.del   = accept && ok && (req_bus.opcode == OP_DELETE);
      cmd.edit  = accept && ok && (req_bus.opcode == OP_EDIT);
      cmd.pos   = req_bus.position;
      cmd.value = req_bus.entry_value;
   end

   // Row of cells, each linked to both neighbors
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_entry;
      logic signed [DATA_W-1:0] right_entry;

      if (g == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_left
         assign left_entry = cell_entry[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_right
         assign right_entry = cell_entry[g+1];
      end

      pidt_cell #(
         .INDEX (g),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .length      (len_ff),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[g])
      );
   end

   // Read one entry for the response
   always_comb begin
      rsp_status_in = !ok;
      rsp_read_in   = '0;
      if (ok && req_bus.opcode == OP_READ) begin
         rsp_read_in = cell_entry[IDX_W'(req_bus.position)];
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            len_ff <= len_in;
         end
      end
   end

   // Load the response word on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_read_ff   <= rsp_read_in;
         rsp_len_ff    <= LEN_OUT_W'(len_in);
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.read_value     = rsp_read_ff;
   assign rsp_bus.current_length = rsp_len_ff;

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(len_ff) <= DEPTH_C)
      else $error("length above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> len_ff == $past(len_ff) + 1'b1)
      else $error("insert did not grow length");

   a_refused_keeps_len: assert property (@(posedge clock) disable iff (reset)
      accept && !ok && req_bus.opcode != OP_SET_LENGTH |=> $stable(len_ff))
      else $error("refused operation changed length");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && rsp_len_ff == LEN_OUT_W'(len_ff))
      else $error("response word not loaded");

   a_error_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> rsp_read_ff == '0)
      else $error("error response carries read data");
`endif

endmodule

/* src/pidt_cell.sv */
// ----------------------------------------------------------------------------
// pidt_cell: one entry of the table
// Holds one entry and picks its next value from the broadcast command, the
// left neighbor (shift up on insert) or the right neighbor (shift down on
// delete).
// ----------------------------------------------------------------------------
module pidt_cell import pidt_pkg::*; #(
   parameter int INDEX = 0,
   parameter int LEN_W = 8
) (
   input  logic                     clock,
   input  pidt_cmd_type             cmd,
   input  logic [LEN_W-1:0]         length,
   input  logic signed [DATA_W-1:0] left_entry,
   input  logic signed [DATA_W-1:0] right_entry,
   output logic signed [DATA_W-1:0] entry
);

   localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
   localparam logic [CMP_W-1:0] MY_IDX  = CMP_W'(INDEX);
   localparam logic [CMP_W-1:0] MY_NEXT = CMP_W'(INDEX + 1);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic [CMP_W-1:0]         pos_c;
   logic [CMP_W-1:0]         len_c;

   assign pos_c = CMP_W'(cmd.pos);
   assign len_c = CMP_W'(length);

   // Select next entry: write at the position, shift inside the live range
   always_comb begin
      entry_in = entry_ff;
      if ((cmd.edit || cmd.ins) && MY_IDX == pos_c) begin
         entry_in = cmd.value;
      end else if (cmd.ins && MY_IDX > pos_c && MY_IDX <= len_c) begin
         entry_in = left_entry;
      end else if (cmd.del && MY_IDX >= pos_c && MY_NEXT < len_c) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
